// ===== rtl/lmdd_pkg.sv =====
`timescale 1ns / 1ps

package lmdd_pkg;

    // default sizes of the lock manager
    localparam int MAX_TXN_DEF      = 8;
    localparam int LOCK_ENTRIES_DEF = 16;
    localparam int MAX_HOLDS_DEF    = 3;

    // per-entry sharer count limit and its width
    localparam int SHW         = 5;
    localparam int SHARERS_MAX = 31;

    // request function codes
    localparam logic [1:0] FN_BEGIN   = 2'd0;
    localparam logic [1:0] FN_ACQUIRE = 2'd1;
    localparam logic [1:0] FN_COMMIT  = 2'd2;
    localparam logic [1:0] FN_ABORT   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_REFUSED  = 3'd1;
    localparam logic [2:0] ST_WAIT     = 3'd2;
    localparam logic [2:0] ST_DEADLOCK = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // datapath operations issued by the controller
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_BEGIN     = 4'd2;
    localparam logic [3:0] OP_REFUSE    = 4'd3;
    localparam logic [3:0] OP_ACQ_START = 4'd4;
    localparam logic [3:0] OP_RD        = 4'd5;
    localparam logic [3:0] OP_SEV       = 4'd6;
    localparam logic [3:0] OP_ENT_RD    = 4'd7;
    localparam logic [3:0] OP_FULL      = 4'd8;
    localparam logic [3:0] OP_DEC       = 4'd9;
    localparam logic [3:0] OP_CYC       = 4'd10;
    localparam logic [3:0] OP_CHK       = 4'd11;
    localparam logic [3:0] OP_REL_START = 4'd12;
    localparam logic [3:0] OP_RWR       = 4'd13;
    localparam logic [3:0] OP_CLR       = 4'd14;

    typedef struct packed {
        logic [3:0] op;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       txn_ok;
        logic       target_ok;
        logic       grant;
        logic       scan_last;
        logic       cyc_last;
        logic       cycle;
        logic       clr_last;
    } t_stat;

endpackage

// ===== rtl/lmdd_if.sv =====
`timescale 1ns / 1ps

interface lmdd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  txn_id;
    logic [30:0] res_key;
    logic        whole_tbl;
    logic        exclusive;

    modport source (output valid, func, txn_id, res_key, whole_tbl, exclusive,
                    input ready);
    modport sink (input valid, func, txn_id, res_key, whole_tbl, exclusive,
                  output ready);
endinterface

interface lmdd_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] new_txn_id;

    modport source (output valid, status, new_txn_id, input ready);
    modport sink (input valid, status, new_txn_id, output ready);
endinterface

// ===== rtl/lmdd_ctrl.sv =====
`timescale 1ns / 1ps

module lmdd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  lmdd_pkg::t_stat i_stat,
    output lmdd_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_SRD  = 4'd3;
    localparam logic [3:0] S_SEV  = 4'd4;
    localparam logic [3:0] S_ERD  = 4'd5;
    localparam logic [3:0] S_DEC  = 4'd6;
    localparam logic [3:0] S_CYC  = 4'd7;
    localparam logic [3:0] S_CHK  = 4'd8;
    localparam logic [3:0] S_RRD  = 4'd9;
    localparam logic [3:0] S_RWR  = 4'd10;
    localparam logic [3:0] S_RESP = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state         = r_state;
        o_cmd.op        = lmdd_pkg::OP_NONE;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.op = lmdd_pkg::OP_CLR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = lmdd_pkg::OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_RESP;
                if (i_stat.func == lmdd_pkg::FN_BEGIN) begin
                    o_cmd.op = lmdd_pkg::OP_BEGIN;
                end else if (!i_stat.txn_ok) begin
                    o_cmd.op = lmdd_pkg::OP_REFUSE;
                end else if (i_stat.func == lmdd_pkg::FN_ACQUIRE) begin
                    o_cmd.op = lmdd_pkg::OP_ACQ_START;
                    n_state  = S_SRD;
                end else begin
                    o_cmd.op = lmdd_pkg::OP_REL_START;
                    n_state  = S_RRD;
                end
            end
            S_SRD: begin
                o_cmd.op = lmdd_pkg::OP_RD;
                n_state  = S_SEV;
            end
            S_SEV: begin
                o_cmd.op = lmdd_pkg::OP_SEV;
                n_state  = i_stat.scan_last ? S_ERD : S_SRD;
            end
            S_ERD: begin
                if (i_stat.target_ok) begin
                    o_cmd.op = lmdd_pkg::OP_ENT_RD;
                    n_state  = S_DEC;
                end else begin
                    o_cmd.op = lmdd_pkg::OP_FULL;
                    n_state  = S_RESP;
                end
            end
            S_DEC: begin
                o_cmd.op = lmdd_pkg::OP_DEC;
                n_state  = i_stat.grant ? S_RESP : S_CYC;
            end
            S_CYC: begin
                o_cmd.op = lmdd_pkg::OP_CYC;
                if (i_stat.cyc_last) n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.op = lmdd_pkg::OP_CHK;
                n_state  = i_stat.cycle ? S_RRD : S_RESP;
            end
            S_RRD: begin
                o_cmd.op = lmdd_pkg::OP_RD;
                n_state  = S_RWR;
            end
            S_RWR: begin
                o_cmd.op = lmdd_pkg::OP_RWR;
                n_state  = i_stat.scan_last ? S_RESP : S_RRD;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/lmdd_dp.sv =====
`timescale 1ns / 1ps

module lmdd_dp #(
    parameter int MAX_TXN      = lmdd_pkg::MAX_TXN_DEF,
    parameter int LOCK_ENTRIES = lmdd_pkg::LOCK_ENTRIES_DEF,
    parameter int MAX_HOLDS    = lmdd_pkg::MAX_HOLDS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lmdd_pkg::t_cmd  i_cmd,
    output lmdd_pkg::t_stat o_stat,
    input  logic [1:0]      i_func,
    input  logic [7:0]      i_txn_id,
    input  logic [30:0]     i_res_key,
    input  logic            i_whole_tbl,
    input  logic            i_exclusive,
    output logic [2:0]      o_status,
    output logic [3:0]      o_new_txn_id
);

    localparam int SW  = (MAX_TXN > 1) ? $clog2(MAX_TXN) : 1;
    localparam int OW  = $clog2(MAX_TXN + 1);
    localparam int EW  = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
    localparam int HW  = $clog2(MAX_HOLDS + 1);
    localparam int SHW = lmdd_pkg::SHW;
    localparam int EDW = 31 + 1 + SHW + OW;
    localparam int HAW = SW + EW;
    localparam int NW  = OW + 4;
    localparam logic [EW-1:0] E_LAST = EW'(LOCK_ENTRIES - 1);
    localparam logic [SW-1:0] T_LAST = SW'(MAX_TXN - 1);
    localparam logic [HW-1:0] H_MAX  = HW'(MAX_HOLDS);
    localparam logic [SHW-1:0] SH_MAX = SHW'(lmdd_pkg::SHARERS_MAX);

    // entry store and per-transaction hold counts
    logic [EDW-1:0] m_ent  [LOCK_ENTRIES];
    logic [HW-1:0]  m_hold [2**HAW];
    logic [EDW-1:0] r_rd_ent;
    logic [HW-1:0]  r_rd_hold;

    // latched request
    logic [1:0]  r_func;
    logic [7:0]  r_tid;
    logic [30:0] r_res;
    logic        r_tbl;
    logic        r_excl;

    logic [LOCK_ENTRIES-1:0] r_valid;
    logic [MAX_TXN-1:0]      r_active;
    logic [OW-1:0]           r_slots;
    logic [MAX_TXN-1:0]      r_waits [MAX_TXN];
    logic [MAX_TXN-1:0]      r_reach [MAX_TXN];
    logic [EW-1:0]           r_cnt;
    logic                    r_found, r_free, r_new;
    logic [EW-1:0]           r_midx, r_fidx, r_tgt;
    logic [SW-1:0]           r_k, r_i;
    logic                    r_edge;
    logic [SW-1:0]           r_ebit;
    logic [HAW-1:0]          r_clr;
    logic [2:0]              r_status;
    logic [3:0]              r_newid;
    logic [2:0]              r_o_status;
    logic [3:0]              r_o_newid;

    logic [SW-1:0]  slot;
    logic [OW-1:0]  my_id;
    logic [7:0]     tid_m1;
    logic [NW-1:0]  next_id;
    logic [30:0]    rd_res;
    logic           rd_tbl;
    logic [SHW-1:0] rd_sh;
    logic [OW-1:0]  rd_own;
    logic [SHW-1:0] cur_sh;
    logic [OW-1:0]  cur_own;
    logic           grant, overflow;
    logic [MAX_TXN-1:0] row_new;
    logic [MAX_TXN-1:0] diag;
    logic [MAX_TXN-1:0] edge_row;
    logic [SHW-1:0] rel_sh;
    logic [OW-1:0]  rel_own;
    logic [EW-1:0]  ent_raddr;
    logic           ent_we;
    logic [EW-1:0]  ent_waddr;
    logic [EDW-1:0] ent_wdata;
    logic           hold_we;
    logic [HAW-1:0] hold_waddr;
    logic [HW-1:0]  hold_wdata;
    logic [EW-1:0]  tgt_sel;

    assign tid_m1  = r_tid - 8'd1;
    assign slot    = tid_m1[SW-1:0];
    assign my_id   = OW'(slot) + OW'(1);
    assign next_id = NW'(r_slots) + NW'(1);
    assign {rd_res, rd_tbl, rd_sh, rd_own} = r_rd_ent;
    assign cur_sh  = r_new ? '0 : rd_sh;
    assign cur_own = r_new ? '0 : rd_own;
    assign tgt_sel = r_found ? r_midx : r_fidx;

    // grant rule and hold overflow on the target entry
    always_comb begin
        if (!r_excl) begin
            grant = (cur_own == '0) || (cur_own == my_id);
        end else begin
            grant = ((cur_own == '0) && (cur_sh == '0)) || (cur_own == my_id) ||
                    ((cur_own == '0) && (cur_sh == SHW'(1)) && (r_rd_hold != '0));
        end
        overflow = !r_excl && ((r_rd_hold >= H_MAX) || (cur_sh >= SH_MAX));
    end

    // waits-for edge from the requester to the current owner, if any
    always_comb begin
        edge_row = '0;
        if (cur_own != '0) edge_row[SW'(cur_own - OW'(1))] = 1'b1;
    end

    // one row of the reachability closure
    always_comb begin
        row_new = r_reach[r_i];
        for (int j = 0; j < MAX_TXN; j++) begin
            if (r_reach[r_i][j]) row_new = row_new | r_reach[j];
        end
        for (int j = 0; j < MAX_TXN; j++) diag[j] = r_reach[j][j];
    end

    // release of one entry
    always_comb begin
        rel_sh  = (SHW'(r_rd_hold) > rd_sh) ? '0 : rd_sh - SHW'(r_rd_hold);
        rel_own = (rd_own == my_id) ? '0 : rd_own;
    end

    // memory ports
    always_comb begin
        ent_raddr  = (i_cmd.op == lmdd_pkg::OP_ENT_RD) ? tgt_sel : r_cnt;
        ent_we     = 1'b0;
        ent_waddr  = r_tgt;
        ent_wdata  = {r_res, r_tbl, cur_sh, cur_own};
        hold_we    = 1'b0;
        hold_waddr = {slot, r_tgt};
        hold_wdata = r_rd_hold + HW'(1);
        case (i_cmd.op)
            lmdd_pkg::OP_DEC: begin
                if (grant && !overflow) begin
                    ent_we = 1'b1;
                    if (!r_excl) begin
                        ent_wdata = {r_res, r_tbl, cur_sh + SHW'(1), cur_own};
                        hold_we   = 1'b1;
                    end else begin
                        ent_wdata = {r_res, r_tbl, cur_sh, my_id};
                    end
                end
            end
            lmdd_pkg::OP_RWR: begin
                ent_we     = r_valid[r_cnt];
                ent_waddr  = r_cnt;
                ent_wdata  = {rd_res, rd_tbl, rel_sh, rel_own};
                hold_we    = 1'b1;
                hold_waddr = {slot, r_cnt};
                hold_wdata = '0;
            end
            lmdd_pkg::OP_CLR: begin
                hold_we    = 1'b1;
                hold_waddr = r_clr;
                hold_wdata = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) m_ent[ent_waddr] <= ent_wdata;
        r_rd_ent <= m_ent[ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (hold_we) m_hold[hold_waddr] <= hold_wdata;
        r_rd_hold <= m_hold[{slot, ent_raddr}];
    end

    // request latch and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == lmdd_pkg::OP_LOAD) begin
            r_func <= i_func;
            r_tid  <= i_txn_id;
            r_res  <= i_res_key;
            r_tbl  <= i_whole_tbl;
            r_excl <= i_exclusive;
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_newid  <= r_newid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_active <= '0;
            r_slots  <= '0;
            for (int t = 0; t < MAX_TXN; t++) begin
                r_waits[t] <= '0;
                r_reach[t] <= '0;
            end
            r_cnt    <= '0;
            r_found  <= 1'b0;
            r_free   <= 1'b0;
            r_new    <= 1'b0;
            r_midx   <= '0;
            r_fidx   <= '0;
            r_tgt    <= '0;
            r_k      <= '0;
            r_i      <= '0;
            r_edge   <= 1'b0;
            r_ebit   <= '0;
            r_clr    <= '0;
            r_status <= lmdd_pkg::ST_OK;
            r_newid  <= '0;
        end else begin
            case (i_cmd.op)
                lmdd_pkg::OP_LOAD: begin
                    r_newid  <= '0;
                    r_status <= lmdd_pkg::ST_REFUSED;
                end
                lmdd_pkg::OP_BEGIN: begin
                    if (r_slots < OW'(MAX_TXN)) begin
                        r_active[r_slots[SW-1:0]] <= 1'b1;
                        r_slots  <= next_id[OW-1:0];
                        r_newid  <= next_id[3:0];
                        r_status <= lmdd_pkg::ST_OK;
                    end
                end
                lmdd_pkg::OP_REFUSE: r_status <= lmdd_pkg::ST_REFUSED;
                lmdd_pkg::OP_ACQ_START: begin
                    r_waits[slot] <= '0;
                    r_cnt   <= '0;
                    r_found <= 1'b0;
                    r_free  <= 1'b0;
                end
                lmdd_pkg::OP_SEV: begin
                    if (r_valid[r_cnt]) begin
                        if (!r_found && rd_res == r_res && rd_tbl == r_tbl) begin
                            r_found <= 1'b1;
                            r_midx  <= r_cnt;
                        end
                    end else if (!r_free) begin
                        r_free <= 1'b1;
                        r_fidx <= r_cnt;
                    end
                    r_cnt <= r_cnt + EW'(1);
                end
                lmdd_pkg::OP_ENT_RD: begin
                    r_tgt <= tgt_sel;
                    r_new <= !r_found;
                end
                lmdd_pkg::OP_FULL: r_status <= lmdd_pkg::ST_FULL;
                lmdd_pkg::OP_DEC: begin
                    if (grant) begin
                        if (overflow) begin
                            r_status <= lmdd_pkg::ST_FULL;
                        end else begin
                            r_status <= lmdd_pkg::ST_OK;
                            r_valid[r_tgt] <= 1'b1;
                        end
                    end else begin
                        // add the edge, then seed the closure with the whole matrix
                        r_edge <= (cur_own != '0);
                        r_ebit <= SW'(cur_own - OW'(1));
                        for (int t = 0; t < MAX_TXN; t++)
                            r_reach[t] <= (SW'(t) == slot) ? (r_waits[t] | edge_row)
                                                           : r_waits[t];
                        r_waits[slot] <= r_waits[slot] | edge_row;
                        r_k <= '0;
                        r_i <= '0;
                    end
                end
                lmdd_pkg::OP_CYC: begin
                    r_reach[r_i] <= row_new;
                    if (r_i == T_LAST) begin
                        r_i <= '0;
                        r_k <= r_k + SW'(1);
                    end else begin
                        r_i <= r_i + SW'(1);
                    end
                end
                lmdd_pkg::OP_CHK: begin
                    if (|diag) begin
                        if (r_edge) r_waits[slot][r_ebit] <= 1'b0;
                        r_status <= lmdd_pkg::ST_DEADLOCK;
                        r_cnt    <= '0;
                    end else begin
                        r_status <= lmdd_pkg::ST_WAIT;
                    end
                end
                lmdd_pkg::OP_REL_START: begin
                    r_status <= lmdd_pkg::ST_OK;
                    r_cnt    <= '0;
                end
                lmdd_pkg::OP_RWR: begin
                    if (r_valid[r_cnt] && rel_sh == '0 && rel_own == '0)
                        r_valid[r_cnt] <= 1'b0;
                    if (r_cnt == E_LAST) r_active[slot] <= 1'b0;
                    r_cnt <= r_cnt + EW'(1);
                end
                lmdd_pkg::OP_CLR: r_clr <= r_clr + HAW'(1);
                default: ;
            endcase
        end
    end

    assign o_stat.func      = r_func;
    assign o_stat.txn_ok    = (r_tid != 8'd0) && (r_tid <= 8'(r_slots)) && r_active[slot];
    assign o_stat.target_ok = r_found || r_free;
    assign o_stat.grant     = grant;
    assign o_stat.scan_last = (r_cnt == E_LAST);
    assign o_stat.cyc_last  = (r_i == T_LAST) && (r_k == T_LAST);
    assign o_stat.cycle     = |diag;
    assign o_stat.clr_last  = &r_clr;
    assign o_status         = r_o_status;
    assign o_new_txn_id     = r_o_newid;

endmodule

// ===== rtl/lock_manager_deadlock_detect_unit.sv =====
`timescale 1ns / 1ps

// Shared/exclusive lock manager with waits-for deadlock detection.
// i_req carries one request transaction (begin, acquire, commit, abort);
// o_rsp returns exactly one result transaction per request, in order.
// Requests are taken one at a time: i_req.ready is high only while the
// controller is idle, so each request runs to completion before the next.
// Work per request, L = LOCK_ENTRIES, T = MAX_TXN:
//   begin, or any request from an unknown transaction : dispatch only
//   commit / abort : read then write back every one of the L entries
//   acquire granted : search of all L entries, one memory port per step
//   acquire refused : adds the waits-for closure, T passes over the T
//   matrix rows, one row a cycle; a deadlock adds the release sweep.
// The result sits in an output register, so a new request is accepted
// while the previous result still waits for o_rsp.ready; if the receiver
// stalls, the next result is held in the controller until the register
// frees up. After reset the hold-count memory is cleared, one word a
// cycle, all 2**(clog2(T)+clog2(L)) words (128 at the defaults), with
// i_req.ready low; all entries, transactions and waits are then empty.
module lock_manager_deadlock_detect_unit #(
    parameter int MAX_TXN      = lmdd_pkg::MAX_TXN_DEF,
    parameter int LOCK_ENTRIES = lmdd_pkg::LOCK_ENTRIES_DEF,
    parameter int MAX_HOLDS    = lmdd_pkg::MAX_HOLDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmdd_req_if.sink    i_req,
    lmdd_rsp_if.source  o_rsp
);

    lmdd_pkg::t_cmd  cmd;
    lmdd_pkg::t_stat stat;

    // sequencing: accept, dispatch, sweep, hand the result over
    lmdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // lock table, hold counts, waits-for matrix and result registers
    lmdd_dp #(
        .MAX_TXN      (MAX_TXN),
        .LOCK_ENTRIES (LOCK_ENTRIES),
        .MAX_HOLDS    (MAX_HOLDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_func        (i_req.func),
        .i_txn_id      (i_req.txn_id),
        .i_res_key     (i_req.res_key),
        .i_whole_tbl   (i_req.whole_tbl),
        .i_exclusive   (i_req.exclusive),
        .o_status      (o_rsp.status),
        .o_new_txn_id  (o_rsp.new_txn_id)
    );

endmodule
